// ===== src/rdq_pkg.sv =====
// ----------------------------------------------------------------------------
// rdq_pkg
// Shared constants, codes, types and pointer helpers for the ring deque.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rdq_pkg;

  // storage geometry
  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // channel field widths
  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int KEY_W    = 32;
  localparam int POS_W    = 4;
  localparam int DOUT_W   = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);

  // operation codes
  localparam logic [OPCODE_W-1:0] OP_PUSH     = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_POP      = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_NEW  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_PEEK_NEW = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_GET      = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_SEARCH   = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_REMOVE   = 3'd6;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  // slot index p + d, wrapped at the capacity
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] p,
                                                input logic [PTR_W-1:0] d);
    logic [PTR_W:0] s;
    s = {1'b0, p} + {1'b0, d};
    if (s >= (PTR_W + 1)'(CAPACITY)) begin
      s = s - (PTR_W + 1)'(CAPACITY);
    end
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] wrap_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? LAST_PTR : p - 1'b1;
  endfunction

endpackage

`default_nettype wire

// ===== src/rdq_ifs.sv =====
// ----------------------------------------------------------------------------
// rdq_ifs
// Request and response channels of the ring deque, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rdq_req_if import rdq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [VALUE_W-1:0]  value;
  logic [KEY_W-1:0]    key;
  logic [POS_W-1:0]    position;

  modport source (output valid, opcode, value, key, position, input ready);
  modport sink   (input valid, opcode, value, key, position, output ready);
endinterface

interface rdq_rsp_if import rdq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DOUT_W-1:0]   data;
  logic [STATUS_W-1:0] status;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, data, status, occupancy, input ready);
  modport sink   (input valid, data, status, occupancy, output ready);
endinterface

`default_nettype wire

// ===== src/ring_deque_with_keyed_remove.sv =====
// ----------------------------------------------------------------------------
// ring_deque_with_keyed_remove
// Fixed-capacity circular deque with push, pops, peek, get, search, remove.
// ----------------------------------------------------------------------------
// Usage: requests arrive on in_req (opcode, value, key, position) and each
// produces exactly one response on out_rsp (data, status, occupancy).
// A transfer happens when valid and ready are both high at a rising edge.
// The words live in a single-port-write, single-port-read memory with a
// registered read; the controller takes one request at a time.
// Push, refused ops, an empty deque and an unknown opcode go straight to the
// response register; pop, pop newest, peek and get first do a registered
// memory read; search scans from the oldest word, up to 16 slots; remove
// searches, then shifts up to 8 words to close the gap.
// Scanning and shifting move one slot per cycle through the memory read
// port. in_req.ready is high while the controller is idle, which it is again
// from the edge that loads the response register, so the next request is
// taken only once the current one has been answered. The response sits in an
// output register, so a new request is accepted while a result still waits.
// A stalled receiver holds the response and stops the next completion only.
// Synchronous active-low reset empties the deque; the memory itself is not
// cleared.
`timescale 1ns / 1ps
`default_nettype none

module ring_deque_with_keyed_remove import rdq_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rdq_req_if.sink    in_req,
  rdq_rsp_if.source  out_rsp
);

  logic [DATA_WIDTH-1:0] slot_mem [CAPACITY];

  state_t                state_r, state_nxt;
  logic [OPCODE_W-1:0]   op_r, op_nxt;
  logic [DATA_WIDTH-1:0] key_r, key_nxt;
  logic [PTR_W-1:0]      idx_r, idx_nxt;
  logic [PTR_W-1:0]      sh_r, sh_nxt;
  logic                  up_r, up_nxt;
  logic [PTR_W-1:0]      oldest_r, oldest_nxt;
  logic [PTR_W-1:0]      newest_r, newest_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [DOUT_W-1:0]     res_data_r, res_data_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DOUT_W-1:0]     out_data_r, out_data_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [OCC_W-1:0]      out_occ_r, out_occ_nxt;

  logic [DATA_WIDTH-1:0] rd_data_r;
  logic [PTR_W-1:0]      rd_addr;
  logic                  mem_we;
  logic [PTR_W-1:0]      mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  fin_up, fin_down;
  logic                  req_xfer;
  logic [CNT_W-1:0]      idx_ext, sh_ext;

  assign in_req.ready      = (state_r == S_IDLE);
  assign req_xfer          = in_req.valid && in_req.ready;
  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.data      = out_data_r;
  assign out_rsp.status    = out_status_r;
  assign out_rsp.occupancy = out_occ_r;

  assign idx_ext = CNT_W'(idx_r);
  assign sh_ext  = CNT_W'(sh_r);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    idx_nxt        = idx_r;
    sh_nxt         = sh_r;
    up_nxt         = up_r;
    oldest_nxt     = oldest_r;
    newest_nxt     = newest_r;
    count_nxt      = count_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_occ_nxt    = out_occ_r;
    rd_addr        = oldest_r;
    mem_we         = 1'b0;
    mem_waddr      = newest_r;
    mem_wdata      = in_req.value[DATA_WIDTH-1:0];
    fin_up         = 1'b0;
    fin_down       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (req_xfer) begin
          op_nxt         = in_req.opcode;
          key_nxt        = in_req.key[DATA_WIDTH-1:0];
          res_data_nxt   = '0;
          res_status_nxt = ST_OK;
          state_nxt      = S_RESP;
          if (in_req.opcode == OP_PUSH) begin
            if (count_r == CAP_CNT) begin
              res_status_nxt = ST_FULL;
            end else begin
              mem_we     = 1'b1;
              newest_nxt = wrap_inc(newest_r);
              count_nxt  = count_r + 1'b1;
            end
          end else if (in_req.opcode == OP_POP || in_req.opcode == OP_POP_NEW ||
                       in_req.opcode == OP_PEEK_NEW || in_req.opcode == OP_GET ||
                       in_req.opcode == OP_SEARCH || in_req.opcode == OP_REMOVE) begin
            if (count_r == '0) begin
              res_status_nxt = ST_EMPTY;
            end else if (in_req.opcode == OP_POP) begin
              rd_addr    = oldest_r;
              oldest_nxt = wrap_inc(oldest_r);
              count_nxt  = count_r - 1'b1;
              state_nxt  = S_READ;
            end else if (in_req.opcode == OP_POP_NEW) begin
              rd_addr    = wrap_dec(newest_r);
              newest_nxt = wrap_dec(newest_r);
              count_nxt  = count_r - 1'b1;
              state_nxt  = S_READ;
            end else if (in_req.opcode == OP_PEEK_NEW) begin
              rd_addr   = wrap_dec(newest_r);
              state_nxt = S_READ;
            end else if (in_req.opcode == OP_GET) begin
              if (CNT_W'(in_req.position) >= count_r) begin
                res_status_nxt = ST_MISS;
              end else begin
                rd_addr   = wrap_add(oldest_r, PTR_W'(in_req.position));
                state_nxt = S_READ;
              end
            end else begin
              // search and remove start the scan at the oldest word
              rd_addr   = oldest_r;
              idx_nxt   = '0;
              state_nxt = S_SCAN;
            end
          end
        end
      end

      S_READ: begin
        res_data_nxt = DOUT_W'(rd_data_r);
        state_nxt    = S_RESP;
      end

      S_SCAN: begin
        // rd_data_r holds the word at position idx_r; next read is issued ahead
        rd_addr = wrap_add(oldest_r, idx_r + 1'b1);
        if (rd_data_r == key_r) begin
          res_data_nxt = DOUT_W'(rd_data_r);
          state_nxt    = S_RESP;
          if (op_r == OP_REMOVE) begin
            if (idx_ext > (count_r >> 1)) begin
              up_nxt = 1'b1;
              if (idx_ext + 1'b1 < count_r) begin
                sh_nxt    = idx_r + 1'b1;
                state_nxt = S_SHIFT;
              end else begin
                fin_up = 1'b1;
              end
            end else begin
              up_nxt = 1'b0;
              if (idx_r != '0) begin
                rd_addr   = wrap_add(oldest_r, idx_r - 1'b1);
                sh_nxt    = idx_r - 1'b1;
                state_nxt = S_SHIFT;
              end else begin
                fin_down = 1'b1;
              end
            end
          end
        end else if (idx_ext + 1'b1 >= count_r) begin
          res_status_nxt = ST_MISS;
          state_nxt      = S_RESP;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_wdata = rd_data_r;
        if (up_r) begin
          // newer words move one slot toward the oldest end
          mem_waddr = wrap_add(oldest_r, sh_r - 1'b1);
          rd_addr   = wrap_add(oldest_r, sh_r + 1'b1);
          if (sh_ext + 1'b1 < count_r) begin
            sh_nxt = sh_r + 1'b1;
          end else begin
            fin_up    = 1'b1;
            state_nxt = S_RESP;
          end
        end else begin
          // older words move one slot toward the newest end
          mem_waddr = wrap_add(oldest_r, sh_r + 1'b1);
          rd_addr   = wrap_add(oldest_r, sh_r - 1'b1);
          if (sh_r != '0) begin
            sh_nxt = sh_r - 1'b1;
          end else begin
            fin_down  = 1'b1;
            state_nxt = S_RESP;
          end
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = res_data_r;
          out_status_nxt = res_status_r;
          out_occ_nxt    = OCC_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin_up) begin
      newest_nxt = wrap_dec(newest_r);
      count_nxt  = count_r - 1'b1;
    end
    if (fin_down) begin
      oldest_nxt = wrap_inc(oldest_r);
      count_nxt  = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= slot_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      oldest_r    <= '0;
      newest_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      newest_r    <= newest_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    idx_r        <= idx_nxt;
    sh_r         <= sh_nxt;
    up_r         <= up_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("occupancy above capacity");

  a_ptr_consistent : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |->
      ((count_r == CAP_CNT) && (newest_r == oldest_r)) ||
      ((count_r != CAP_CNT) && (wrap_add(oldest_r, PTR_W'(count_r)) == newest_r)))
    else $error("newest pointer does not match oldest plus count");

  a_full_status : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FULL) |-> (out_occ_r == OCC_W'(CAPACITY)))
    else $error("full status reported below capacity");

  a_write_state : assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((state_r == S_IDLE && req_xfer) || state_r == S_SHIFT))
    else $error("memory write outside push or shift");

endmodule

`default_nettype wire
